[src/iirdf1_pkg.sv]
`timescale 1ns / 1ps

package iirdf1_pkg;

  // field and coefficient widths
  localparam int unsigned DataW    = 16;
  localparam int unsigned CoefW    = 32;
  localparam int unsigned OutW     = 10;
  localparam int unsigned FracBits = 16;

  // clamp ceiling of the output word
  localparam int unsigned OutMax = 1023;

  // filter order and coefficient reset values (unity gain on the current sample)
  localparam int unsigned DefaultOrder = 2;
  localparam logic [CoefW-1:0] Ff0Reset = 32'h0001_0000;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic [OutW-1:0]         out_t;
  typedef logic [CoefW-1:0]        coef_t;

  // datapath result: raw feedback value and clamped output
  typedef struct packed {
    logic [DataW-1:0] raw;
    out_t             clamped;
  } dp_res_t;

endpackage

[src/iirdf1_in_if.sv]
`timescale 1ns / 1ps

interface iirdf1_in_if;
  logic                 valid;
  logic                 ready;
  iirdf1_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

[src/iirdf1_out_if.sv]
`timescale 1ns / 1ps

interface iirdf1_out_if;
  logic              valid;
  logic              ready;
  iirdf1_pkg::out_t  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

[src/iirdf1_datapath.sv]
`timescale 1ns / 1ps

module iirdf1_datapath #(
  parameter int unsigned ORDER = iirdf1_pkg::DefaultOrder
) (
  input  iirdf1_pkg::sample_t                         x,
  input  logic [ORDER:0][iirdf1_pkg::CoefW-1:0]       ff_coef,
  input  logic [ORDER-1:0][iirdf1_pkg::CoefW-1:0]     fb_coef,
  input  logic [ORDER-1:0][iirdf1_pkg::DataW-1:0]     past_x,
  input  logic [ORDER-1:0][iirdf1_pkg::DataW-1:0]     past_y,
  output iirdf1_pkg::dp_res_t                         res
);

  localparam int unsigned DataW = iirdf1_pkg::DataW;
  localparam int unsigned CoefW = iirdf1_pkg::CoefW;
  localparam int unsigned OutW  = iirdf1_pkg::OutW;

  function automatic logic [CoefW-1:0] sext(input logic [DataW-1:0] v);
    return {{(CoefW-DataW){v[DataW-1]}}, v};
  endfunction

  logic [CoefW-1:0] acc;
  logic [DataW-1:0] raw;

  // multiply-accumulate over all taps, wrapping modulo 2^32
  always_comb begin
    acc = ff_coef[0] * sext(x);
    for (int k = 1; k <= ORDER; k++) begin
      acc = acc + ff_coef[k] * sext(past_x[k-1]);
    end
    for (int k = 1; k <= ORDER; k++) begin
      acc = acc - fb_coef[k-1] * sext(past_y[k-1]);
    end
  end

  assign raw = acc[iirdf1_pkg::FracBits +: DataW];

  // clamp to the unsigned output range
  always_comb begin
    res.raw = raw;
    if (raw[DataW-1]) begin
      res.clamped = '0;
    end else if (raw > DataW'(iirdf1_pkg::OutMax)) begin
      res.clamped = OutW'(iirdf1_pkg::OutMax);
    end else begin
      res.clamped = raw[OutW-1:0];
    end
  end

endmodule

[src/iir_direct_form_one_q16_unit.sv]
`timescale 1ns / 1ps

// Direct-form-I IIR filter, Q16 coefficients. Takes one signed 16-bit sample
// per word on in_ch and returns one filtered word on out_ch, clamped to 0..1023.
// Throughput is one word per clock while out_ch does not stall. A result is
// offered on out_ch after its sample has passed the input register and the
// result register. The clock rate is set by the feedback path: all 2*ORDER+1
// 32x16 multiplies and their sum sit between the input register and the
// result/history registers. Coefficients are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no word is in flight, which the
// block does not enforce. Indexes 0..ORDER are ff_coef_0..ff_coef_ORDER,
// ORDER+1..2*ORDER are fb_coef_1..fb_coef_ORDER; other indexes are ignored.
// After reset ff_coef_0 is 1.0 (65536), the rest and both delay lines are zero.
module iir_direct_form_one_q16_unit #(
  parameter int unsigned ORDER = iirdf1_pkg::DefaultOrder,
  localparam int unsigned CfgIdxW = $clog2(2 * ORDER + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  iirdf1_in_if.sink                     in_ch,
  iirdf1_out_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [CfgIdxW-1:0]            cfg_index,
  input  logic [iirdf1_pkg::CoefW-1:0]  cfg_data
);

  localparam int unsigned DataW = iirdf1_pkg::DataW;
  localparam int unsigned CoefW = iirdf1_pkg::CoefW;

  logic [ORDER:0][CoefW-1:0]   ff_coef_r;
  logic [ORDER-1:0][CoefW-1:0] fb_coef_r;
  logic [ORDER-1:0][DataW-1:0] px_r;
  logic [ORDER-1:0][DataW-1:0] py_r;
  iirdf1_pkg::sample_t         xin_r;
  logic                        s1_v_r;
  logic                        out_v_r;
  iirdf1_pkg::out_t            out_sample_r;
  iirdf1_pkg::dp_res_t         dp_res;
  logic                        move;

  // word advances from input register to result register
  assign move        = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || move;

  assign out_ch.valid      = out_v_r;
  assign out_ch.sample_out = out_sample_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_coef_r <= {{(ORDER * CoefW){1'b0}}, iirdf1_pkg::Ff0Reset};
      fb_coef_r <= '0;
    end else if (cfg_we) begin
      for (int k = 0; k <= ORDER; k++) begin
        if (cfg_index == CfgIdxW'(k)) ff_coef_r[k] <= cfg_data;
      end
      for (int k = 0; k < ORDER; k++) begin
        if (cfg_index == CfgIdxW'(ORDER + 1 + k)) fb_coef_r[k] <= cfg_data;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) xin_r <= in_ch.sample_in;
  end

  iirdf1_datapath #(
    .ORDER (ORDER)
  ) u_datapath (
    .x       (xin_r),
    .ff_coef (ff_coef_r),
    .fb_coef (fb_coef_r),
    .past_x  (px_r),
    .past_y  (py_r),
    .res     (dp_res)
  );

  // delay lines shift once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0;
      py_r <= '0;
    end else if (move) begin
      for (int k = ORDER - 1; k > 0; k--) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
      px_r[0] <= xin_r;
      py_r[0] <= dp_res.raw;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (move) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) out_sample_r <= dp_res.clamped;
  end

  // checks
  a_ready_only_blocked_by_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_v_r)
    else $error("result register empty after a word moved");

  a_px_shift: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> px_r[0] == $past(xin_r))
    else $error("input history missed the processed sample");

  a_py_shift: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> py_r[0] == $past(dp_res.raw))
    else $error("output history missed the raw result");

  a_neg_clamps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (move && dp_res.raw[DataW-1]) |=> out_sample_r == '0)
    else $error("negative raw value not clamped to zero");

endmodule
